// ===== src/jnp_pkg.sv =====
// Package for the JSON number parser: item types, accumulator state,
// status codes and exponent sizing constants. No dependencies.

package jnp_pkg;

  localparam int EXP_BITS  = 16;
  localparam int EXP_EFF   = (EXP_BITS < 16) ? EXP_BITS : 16;
  localparam int EXP_SUM_W = EXP_EFF + 2;

  localparam logic [EXP_EFF-1:0] EXP_CAP = {1'b1, {(EXP_EFF-1){1'b0}}};

  localparam logic [63:0] SIG_LIMIT_LO = 64'h0CCC_CCCC_CCCC_CCCC;
  localparam logic [63:0] SIG_LIMIT_HI = 64'h0CCC_CCCC_CCCC_CCCB;

  localparam logic [2:0] ST_INTEGER = 3'd0;
  localparam logic [2:0] ST_SCALED  = 3'd1;
  localparam logic [2:0] ST_NO_INT  = 3'd2;
  localparam logic [2:0] ST_NO_FRAC = 3'd3;
  localparam logic [2:0] ST_NO_EXP  = 3'd4;

  typedef struct packed {
    logic [7:0] char_in;
    logic       text_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic signed [63:0]  significand;
    logic signed [15:0]  exponent;
    logic                overflowed;
    logic [7:0]          stop_char;
  } out_item_t;

  typedef struct packed {
    logic               negative;
    logic [63:0]        sig;
    logic [EXP_EFF-1:0] frac;
    logic               exp_negative;
    logic [EXP_EFF-1:0] expv;
    logic               ovf;
  } acc_t;

  typedef struct packed {
    logic [63:0]        sig;
    logic               sig_ovf;
    logic [EXP_EFF-1:0] frac;
    logic               frac_ovf;
    logic [EXP_EFF-1:0] expv;
    logic               exp_ovf;
  } step_t;

endpackage

// ===== src/jnp_accum.sv =====
// Digit step of the JSON number parser: significand times ten plus digit,
// fraction count bump and exponent accumulate, with saturation. Uses jnp_pkg.

module jnp_accum import jnp_pkg::*; (
  input  acc_t       acc,
  input  logic [3:0] digit,
  output step_t      step
);

  logic [63:0]        limit;
  logic [EXP_EFF+3:0] exp_sum;

  always_comb begin
    limit        = (digit > 4'd7) ? SIG_LIMIT_HI : SIG_LIMIT_LO;
    step.sig     = (acc.sig << 3) + (acc.sig << 1) + {60'b0, digit};
    step.sig_ovf = acc.sig > limit;

    if (acc.frac >= EXP_CAP) begin
      step.frac     = EXP_CAP;
      step.frac_ovf = 1'b1;
    end else begin
      step.frac     = acc.frac + EXP_EFF'(1);
      step.frac_ovf = 1'b0;
    end

    exp_sum = ({4'b0, acc.expv} << 3) + ({4'b0, acc.expv} << 1)
            + {{EXP_EFF{1'b0}}, digit};
    if (exp_sum > {4'b0, EXP_CAP}) begin
      step.expv    = EXP_CAP;
      step.exp_ovf = 1'b1;
    end else begin
      step.expv    = exp_sum[EXP_EFF-1:0];
      step.exp_ovf = 1'b0;
    end
  end

endmodule

// ===== src/jnp_finish.sv =====
// Result assembly of the JSON number parser: signed significand, clamped
// decimal exponent, status and overflow flag. Uses jnp_pkg.

module jnp_finish import jnp_pkg::*; (
  input  acc_t       acc,
  input  logic [7:0] stop_char,
  output out_item_t  res
);

  localparam logic signed [EXP_SUM_W-1:0] E_MAX = EXP_SUM_W'((1 << (EXP_EFF-1)) - 1);
  localparam logic signed [EXP_SUM_W-1:0] E_MIN = EXP_SUM_W'(-(1 << (EXP_EFF-1)));

  logic signed [EXP_SUM_W-1:0] e_mag;
  logic signed [EXP_SUM_W-1:0] e_val;
  logic signed [EXP_SUM_W-1:0] e_cl;
  logic                        clamp;

  always_comb begin
    e_mag = $signed({2'b00, acc.expv});
    e_val = (acc.exp_negative ? -e_mag : e_mag) - $signed({2'b00, acc.frac});
    priority if (e_val > E_MAX) begin
      e_cl  = E_MAX;
      clamp = 1'b1;
    end else if (e_val < E_MIN) begin
      e_cl  = E_MIN;
      clamp = 1'b1;
    end else begin
      e_cl  = e_val;
      clamp = 1'b0;
    end

    res.status      = (e_cl == '0) ? ST_INTEGER : ST_SCALED;
    res.significand = $signed(acc.negative ? (64'd0 - acc.sig) : acc.sig);
    res.exponent    = 16'(e_cl);
    res.overflowed  = acc.ovf | clamp;
    res.stop_char   = stop_char;
  end

endmodule

// ===== src/json_number_parser_unit.sv =====
// Top level of the JSON number parser: phase sequencer, accumulator state
// and result register. Uses jnp_pkg, jnp_accum and jnp_finish.
//
// Takes one text byte per item and accepts an item in every cycle while the
// result register is free or being drained. The byte that ends a number, or
// the byte that breaks it, yields one result item in the register on the next
// cycle; other bytes yield none. Per-byte cost is one 64-bit multiply by ten
// and add with its overflow compare.

module json_number_parser_unit import jnp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_INT_START  = 4'd1,
    PH_INT_DIGITS = 4'd2,
    PH_AFTER_ZERO = 4'd3,
    PH_FRAC_START = 4'd4,
    PH_FRAC_DIGIT = 4'd5,
    PH_EXP_SIGN   = 4'd6,
    PH_EXP_START  = 4'd7,
    PH_EXP_DIGITS = 4'd8
  } phase_t;

  phase_t    phase_r, phase_nxt;
  acc_t      acc_r, acc_nxt;
  logic      out_valid_r;
  out_item_t out_data_r;

  logic       in_fire;
  logic [7:0] c;
  logic       dig;
  logic [3:0] digit;
  step_t      step;
  out_item_t  fin_res;
  out_item_t  res;
  logic       emit;
  logic       fail;
  logic [2:0] fail_code;
  logic       do_sig, do_frac, do_exp;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign c     = in_data.text_end ? 8'h00 : in_data.char_in;
  assign dig   = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit = dig ? c[3:0] : 4'd0;

  jnp_accum u_accum (
    .acc   (acc_r),
    .digit (digit),
    .step  (step)
  );

  jnp_finish u_finish (
    .acc       (acc_r),
    .stop_char (c),
    .res       (fin_res)
  );

  always_comb begin
    phase_nxt = phase_r;
    emit      = 1'b0;
    fail      = 1'b0;
    fail_code = ST_NO_INT;
    do_sig    = 1'b0;
    do_frac   = 1'b0;
    do_exp    = 1'b0;
    acc_nxt   = acc_r;

    unique case (phase_r)
      PH_INT_START: begin
        if (c == CH_ZERO) phase_nxt = PH_AFTER_ZERO;
        else if (dig) begin
          do_sig    = 1'b1;
          phase_nxt = PH_INT_DIGITS;
        end else begin
          fail = 1'b1;
          fail_code = ST_NO_INT;
        end
      end
      PH_INT_DIGITS, PH_AFTER_ZERO: begin
        if (dig && phase_r == PH_INT_DIGITS) do_sig = 1'b1;
        else if (c == CH_DOT) phase_nxt = PH_FRAC_START;
        else if (c == CH_E_LO || c == CH_E_UP) phase_nxt = PH_EXP_SIGN;
        else emit = 1'b1;
      end
      PH_FRAC_START: begin
        if (dig) begin
          do_sig    = 1'b1;
          do_frac   = 1'b1;
          phase_nxt = PH_FRAC_DIGIT;
        end else begin
          fail = 1'b1;
          fail_code = ST_NO_FRAC;
        end
      end
      PH_FRAC_DIGIT: begin
        if (dig) begin
          do_sig  = 1'b1;
          do_frac = 1'b1;
        end else if (c == CH_E_LO || c == CH_E_UP) phase_nxt = PH_EXP_SIGN;
        else emit = 1'b1;
      end
      PH_EXP_SIGN: begin
        if (c == CH_MINUS) begin
          acc_nxt.exp_negative = 1'b1;
          phase_nxt = PH_EXP_START;
        end else if (c == CH_PLUS) phase_nxt = PH_EXP_START;
        else if (dig) begin
          do_exp    = 1'b1;
          phase_nxt = PH_EXP_DIGITS;
        end else begin
          fail = 1'b1;
          fail_code = ST_NO_EXP;
        end
      end
      PH_EXP_START: begin
        if (dig) begin
          do_exp    = 1'b1;
          phase_nxt = PH_EXP_DIGITS;
        end else begin
          fail = 1'b1;
          fail_code = ST_NO_EXP;
        end
      end
      PH_EXP_DIGITS: begin
        if (dig) do_exp = 1'b1;
        else emit = 1'b1;
      end
      default: begin
        acc_nxt = '0;
        if (c == CH_MINUS) begin
          acc_nxt.negative = 1'b1;
          phase_nxt = PH_INT_START;
        end else if (c == CH_ZERO) phase_nxt = PH_AFTER_ZERO;
        else if (dig) begin
          do_sig    = 1'b1;
          phase_nxt = PH_INT_DIGITS;
        end else begin
          fail = 1'b1;
          fail_code = ST_NO_INT;
        end
      end
    endcase

    if (do_sig) begin
      acc_nxt.sig = step.sig;
      acc_nxt.ovf = acc_nxt.ovf | step.sig_ovf;
    end
    if (do_frac) begin
      acc_nxt.frac = step.frac;
      acc_nxt.ovf  = acc_nxt.ovf | step.frac_ovf;
    end
    if (do_exp) begin
      acc_nxt.expv = step.expv;
      acc_nxt.ovf  = acc_nxt.ovf | step.exp_ovf;
    end

    if (fail) begin
      res = '0;
      res.status    = fail_code;
      res.stop_char = c;
    end else begin
      res = fin_res;
    end

    if (emit || fail) begin
      acc_nxt   = '0;
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
      end
      if (in_fire && (emit || fail)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    if (in_fire && (emit || fail)) out_data_r <= res;
  end

endmodule
